// ----- rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 4;
    localparam int HUE_BITS      = 16;

    localparam int CH_MAX       = (1 << CHANNEL_BITS) - 1;
    localparam int SECTOR_UNITS = 60 << HUE_FRAC_BITS;
    localparam int FULL_TURN    = 360 << HUE_FRAC_BITS;

    localparam int TURN_W = $clog2(FULL_TURN + 1);
    localparam int WHEEL_W = (TURN_W > HUE_BITS) ? TURN_W : HUE_BITS;
    localparam int FRAC_W = $clog2(SECTOR_UNITS + 1);
    localparam int SEC_W  = 3;

    // s * frac, and its quotient by the sector size taken as (x >> (F+2)) / 15
    localparam int PROD_W  = CHANNEL_BITS + FRAC_W;
    localparam int QIN_W   = PROD_W - HUE_FRAC_BITS - 2;
    localparam int RSH     = QIN_W + 4;
    localparam int RECIP15 = (1 << RSH) / 15;
    localparam int RMUL_W  = QIN_W + RSH;

    localparam int LEVEL_W = 2 * CHANNEL_BITS;

    localparam logic [SEC_W-1:0] SEC_RED_YELLOW   = SEC_W'(0);
    localparam logic [SEC_W-1:0] SEC_YELLOW_GREEN = SEC_W'(1);
    localparam logic [SEC_W-1:0] SEC_GREEN_CYAN   = SEC_W'(2);
    localparam logic [SEC_W-1:0] SEC_CYAN_BLUE    = SEC_W'(3);
    localparam logic [SEC_W-1:0] SEC_BLUE_MAGENTA = SEC_W'(4);

    typedef struct packed {
        logic [SEC_W-1:0]        sector;
        logic [CHANNEL_BITS-1:0] value;
    } pix_ctl_t;

    // exact floor(x / CH_MAX) for x up to CH_MAX squared
    function automatic logic [CHANNEL_BITS-1:0] div_by_max(input logic [LEVEL_W-1:0] x);
        logic [LEVEL_W:0] x1;
        logic [LEVEL_W:0] sum;
        x1  = {1'b0, x} + (LEVEL_W + 1)'(1);
        sum = x1 + (x1 >> CHANNEL_BITS);
        return sum[CHANNEL_BITS +: CHANNEL_BITS];
    endfunction

endpackage

// ----- rtl/hsv2rgb_sector.sv -----
module hsv2rgb_sector (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      advance,
    input  logic                                      in_valid,
    input  logic [hsv2rgb_pkg::HUE_BITS-1:0]          hue,
    input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      saturation,
    input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      brightness,
    output logic                                      out_valid,
    output hsv2rgb_pkg::pix_ctl_t                     out_ctl,
    output logic [hsv2rgb_pkg::FRAC_W-1:0]            frac,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      sat
);

    logic                                   valid_reg;
    hsv2rgb_pkg::pix_ctl_t                  ctl_reg;
    hsv2rgb_pkg::pix_ctl_t                  ctl_next;
    logic [hsv2rgb_pkg::FRAC_W-1:0]         frac_reg;
    logic [hsv2rgb_pkg::FRAC_W-1:0]         frac_next;
    logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   sat_reg;
    logic [hsv2rgb_pkg::WHEEL_W-1:0]        wheel;
    logic [hsv2rgb_pkg::WHEEL_W-1:0]        base;

    always_comb
    begin
        wheel = hsv2rgb_pkg::WHEEL_W'(hue);
        // a full turn or beyond wraps to zero
        if (wheel >= hsv2rgb_pkg::WHEEL_W'(hsv2rgb_pkg::FULL_TURN))
        begin
            wheel = '0;
        end
        ctl_next.sector = '0;
        ctl_next.value  = brightness;
        base            = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (wheel >= hsv2rgb_pkg::WHEEL_W'(k * hsv2rgb_pkg::SECTOR_UNITS))
            begin
                ctl_next.sector = hsv2rgb_pkg::SEC_W'(k);
                base            = hsv2rgb_pkg::WHEEL_W'(k * hsv2rgb_pkg::SECTOR_UNITS);
            end
        end
        frac_next = hsv2rgb_pkg::FRAC_W'(wheel - base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg  <= ctl_next;
            frac_reg <= frac_next;
            sat_reg  <= saturation;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign frac      = frac_reg;
    assign sat       = sat_reg;

endmodule

// ----- rtl/hsv2rgb_mix.sv -----
module hsv2rgb_mix (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      advance,
    input  logic                                      in_valid,
    input  hsv2rgb_pkg::pix_ctl_t                     in_ctl,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]            frac,
    input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      sat,
    output logic                                      out_valid,
    output hsv2rgb_pkg::pix_ctl_t                     out_ctl,
    output logic [hsv2rgb_pkg::LEVEL_W-1:0]           level_p,
    output logic [hsv2rgb_pkg::LEVEL_W-1:0]           level_q,
    output logic [hsv2rgb_pkg::LEVEL_W-1:0]           level_t
);

    localparam int CW = hsv2rgb_pkg::CHANNEL_BITS;
    localparam int PW = hsv2rgb_pkg::PROD_W;
    localparam int QW = hsv2rgb_pkg::QIN_W;
    localparam int MW = hsv2rgb_pkg::RMUL_W;
    localparam int LW = hsv2rgb_pkg::LEVEL_W;

    logic [3:0]             valid_reg;
    hsv2rgb_pkg::pix_ctl_t  ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [LW-1:0]          pp2_reg, pp3_reg, pp4_reg, pp5_reg;
    logic [PW-1:0]          sq2_reg, st2_reg;
    logic [QW-1:0]          yq3_reg, yt3_reg;
    logic [CW-1:0]          aq3_reg, at3_reg;
    logic [CW-1:0]          aq3_next, at3_next;
    logic [CW-1:0]          dq4_reg, dt4_reg;
    logic [LW-1:0]          mq5_reg, mt5_reg;
    logic [MW-1:0]          rq_full, rt_full;
    logic [QW-1:0]          yq_next, yt_next;

    // reciprocal estimate is exact or one short; the remainder check fixes it
    function automatic logic [CW-1:0] fix_quot(input logic [QW-1:0] y,
                                               input logic [CW-1:0] a);
        logic [QW-1:0] a15;
        logic [QW-1:0] rem;
        a15 = (QW'(a) << 4) - QW'(a);
        rem = y - a15;
        if (rem >= QW'(15))
        begin
            return a + CW'(1);
        end
        return a;
    endfunction

    always_comb
    begin
        yq_next  = QW'(sq2_reg >> (hsv2rgb_pkg::HUE_FRAC_BITS + 2));
        yt_next  = QW'(st2_reg >> (hsv2rgb_pkg::HUE_FRAC_BITS + 2));
        rq_full  = MW'(yq_next) * MW'(hsv2rgb_pkg::RECIP15);
        rt_full  = MW'(yt_next) * MW'(hsv2rgb_pkg::RECIP15);
        aq3_next = rq_full[hsv2rgb_pkg::RSH +: CW];
        at3_next = rt_full[hsv2rgb_pkg::RSH +: CW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // products of saturation with the hue fraction, and the grey level
            ctl2_reg <= in_ctl;
            pp2_reg  <= LW'(in_ctl.value) * LW'(CW'(hsv2rgb_pkg::CH_MAX) - sat);
            sq2_reg  <= PW'(sat) * PW'(frac);
            st2_reg  <= PW'(sat) * PW'(hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::SECTOR_UNITS) - frac);

            // divide by the sector size
            ctl3_reg <= ctl2_reg;
            pp3_reg  <= pp2_reg;
            yq3_reg  <= yq_next;
            yt3_reg  <= yt_next;
            aq3_reg  <= aq3_next;
            at3_reg  <= at3_next;

            ctl4_reg <= ctl3_reg;
            pp4_reg  <= pp3_reg;
            dq4_reg  <= fix_quot(yq3_reg, aq3_reg);
            dt4_reg  <= fix_quot(yt3_reg, at3_reg);

            // scale brightness by the dimmed level
            ctl5_reg <= ctl4_reg;
            pp5_reg  <= pp4_reg;
            mq5_reg  <= LW'(ctl4_reg.value) * LW'(CW'(hsv2rgb_pkg::CH_MAX) - dq4_reg);
            mt5_reg  <= LW'(ctl4_reg.value) * LW'(CW'(hsv2rgb_pkg::CH_MAX) - dt4_reg);
        end
    end

    assign out_valid = valid_reg[3];
    assign out_ctl   = ctl5_reg;
    assign level_p   = pp5_reg;
    assign level_q   = mq5_reg;
    assign level_t   = mt5_reg;

endmodule

// ----- rtl/hsv2rgb_select.sv -----
module hsv2rgb_select (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      advance,
    input  logic                                      in_valid,
    input  hsv2rgb_pkg::pix_ctl_t                     in_ctl,
    input  logic [hsv2rgb_pkg::LEVEL_W-1:0]           level_p,
    input  logic [hsv2rgb_pkg::LEVEL_W-1:0]           level_q,
    input  logic [hsv2rgb_pkg::LEVEL_W-1:0]           level_t,
    output logic                                      out_valid,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      red,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      green,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      blue
);

    localparam int CW = hsv2rgb_pkg::CHANNEL_BITS;

    logic          valid_reg;
    logic [CW-1:0] red_reg, green_reg, blue_reg;
    logic [CW-1:0] red_next, green_next, blue_next;
    logic [CW-1:0] p, q, t, v;

    always_comb
    begin
        p = hsv2rgb_pkg::div_by_max(level_p);
        q = hsv2rgb_pkg::div_by_max(level_q);
        t = hsv2rgb_pkg::div_by_max(level_t);
        v = in_ctl.value;
        case (in_ctl.sector)
            hsv2rgb_pkg::SEC_RED_YELLOW:
            begin
                red_next = v; green_next = t; blue_next = p;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
            begin
                red_next = q; green_next = v; blue_next = p;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN:
            begin
                red_next = p; green_next = v; blue_next = t;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE:
            begin
                red_next = p; green_next = q; blue_next = v;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
            begin
                red_next = t; green_next = p; blue_next = v;
            end
            default:
            begin
                red_next = v; green_next = p; blue_next = q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ----- rtl/hsv_to_rgb_converter_core.sv -----
// A request runs through the sector, mix and select stages to the output register.
// Throughput: one pixel per cycle; the six stages run in lockstep and hold together
// while the output is stalled and a result is waiting.
// Reset: asynchronous, active low; clears every stage valid bit, so no result is
// presented until a new request has passed through.
module hsv_to_rgb_converter_core (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [hsv2rgb_pkg::HUE_BITS-1:0]          hue,
    input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      saturation,
    input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      brightness,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      red,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      green,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]      blue
);

    logic                                   advance;
    logic                                   sec_valid;
    hsv2rgb_pkg::pix_ctl_t                  sec_ctl;
    logic [hsv2rgb_pkg::FRAC_W-1:0]         sec_frac;
    logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   sec_sat;
    logic                                   mix_valid;
    hsv2rgb_pkg::pix_ctl_t                  mix_ctl;
    logic [hsv2rgb_pkg::LEVEL_W-1:0]        mix_p, mix_q, mix_t;

    // advance whenever the output register is empty or being drained
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    hsv2rgb_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (in_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (sec_valid),
        .out_ctl    (sec_ctl),
        .frac       (sec_frac),
        .sat        (sec_sat)
    );

    hsv2rgb_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (sec_valid),
        .in_ctl     (sec_ctl),
        .frac       (sec_frac),
        .sat        (sec_sat),
        .out_valid  (mix_valid),
        .out_ctl    (mix_ctl),
        .level_p    (mix_p),
        .level_q    (mix_q),
        .level_t    (mix_t)
    );

    hsv2rgb_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (mix_valid),
        .in_ctl     (mix_ctl),
        .level_p    (mix_p),
        .level_q    (mix_q),
        .level_t    (mix_t),
        .out_valid  (out_valid),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

// ----- tb/sv/tb.sv -----
module tb;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 12;

    localparam int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS;
    localparam int HUE_BITS     = hsv2rgb_pkg::HUE_BITS;
    localparam int SEC_W        = hsv2rgb_pkg::SEC_W;
    localparam int CH_MAX       = hsv2rgb_pkg::CH_MAX;
    localparam int SECTOR_UNITS = hsv2rgb_pkg::SECTOR_UNITS;
    localparam int FULL_TURN    = hsv2rgb_pkg::FULL_TURN;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_stall;
    logic [HUE_BITS-1:0]     hue        = '0;
    logic [CHANNEL_BITS-1:0] saturation = '0;
    logic [CHANNEL_BITS-1:0] brightness = '0;
    logic                    out_valid;
    logic                    out_stall  = 1'b0;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    rgb_t        expected_rgb[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;
    int unsigned stall_left  = 0;

    hsv_to_rgb_converter_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #CLK_HALF clk = ~clk;

    // level v * (1 - s * part / sector), every division truncated
    function automatic int unsigned dimmed_level(input int unsigned v, input int unsigned s,
                                                 input int unsigned part);
        int unsigned dim;
        dim = (s * part) / SECTOR_UNITS;
        return (v * (CH_MAX - dim)) / CH_MAX;
    endfunction

    function automatic rgb_t predict_rgb(input logic [HUE_BITS-1:0] h,
                                         input logic [CHANNEL_BITS-1:0] s,
                                         input logic [CHANNEL_BITS-1:0] v);
        int unsigned      angle;
        int unsigned      frac;
        logic [SEC_W-1:0] sec;
        int unsigned      p;
        int unsigned      q;
        int unsigned      t;
        rgb_t             res;
        if (s == 0)
        begin
            res = '{v, v, v};
            return res;
        end
        angle = (h >= FULL_TURN) ? 0 : h;
        sec   = SEC_W'(angle / SECTOR_UNITS);
        frac  = angle % SECTOR_UNITS;
        p     = (v * (CH_MAX - s)) / CH_MAX;
        q     = dimmed_level(v, s, frac);
        t     = dimmed_level(v, s, SECTOR_UNITS - frac);
        case (sec)
            hsv2rgb_pkg::SEC_RED_YELLOW:
                res = '{v, t[CHANNEL_BITS-1:0], p[CHANNEL_BITS-1:0]};
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
                res = '{q[CHANNEL_BITS-1:0], v, p[CHANNEL_BITS-1:0]};
            hsv2rgb_pkg::SEC_GREEN_CYAN:
                res = '{p[CHANNEL_BITS-1:0], v, t[CHANNEL_BITS-1:0]};
            hsv2rgb_pkg::SEC_CYAN_BLUE:
                res = '{p[CHANNEL_BITS-1:0], q[CHANNEL_BITS-1:0], v};
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
                res = '{t[CHANNEL_BITS-1:0], p[CHANNEL_BITS-1:0], v};
            default:
                res = '{v, p[CHANNEL_BITS-1:0], q[CHANNEL_BITS-1:0]};
        endcase
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [HUE_BITS-1:0] random_hue();
        int unsigned edge_pt;
        case ($urandom_range(0, 9))
            0: return HUE_BITS'($urandom_range(0, 65535));
            1:
            begin
                edge_pt = $urandom_range(0, 6) * SECTOR_UNITS;
                return HUE_BITS'(edge_pt + $urandom_range(0, 2) - ((edge_pt == 0) ? 0 : 1));
            end
            default: return HUE_BITS'($urandom_range(0, FULL_TURN - 1));
        endcase
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] random_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CHANNEL_BITS'(CH_MAX);
            default: return CHANNEL_BITS'($urandom_range(0, CH_MAX));
        endcase
    endfunction

    task automatic send_request(input logic [HUE_BITS-1:0] h,
                                input logic [CHANNEL_BITS-1:0] s,
                                input logic [CHANNEL_BITS-1:0] v);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_rgb.push_back(predict_rgb(h, s, v));
    endtask

    // hold the input idle until every outstanding request has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_rgb.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        int unsigned wheel_pts[17] = '{0, 480, 959, 960, 1440, 1919, 1920, 2400, 2880,
                                       3360, 3840, 4320, 4800, 5280, 5759, 5760, 65535};
        gap_pct   = 30;
        stall_pct = 20;
        foreach (wheel_pts[i])
            send_request(HUE_BITS'(wheel_pts[i]), 8'd255, 8'd255);
        send_request(16'd1000, 8'd0, 8'd200);
        send_request(16'd65535, 8'd0, 8'd37);
        send_request(16'd6000, 8'd128, 8'd255);
        send_request(16'd2000, 8'd255, 8'd0);
        send_request(16'd3000, 8'd1, 8'd255);
        send_request(16'd4000, 8'd200, 8'd128);
        send_request(16'd32768, 8'd170, 8'd85);
        drain_results();
    endtask

    task automatic test_random_wheel();
        gap_pct   = 25;
        stall_pct = 25;
        repeat (1000)
            send_request(random_hue(), random_level(), random_level());
        drain_results();
    endtask

    task automatic test_back_to_back();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (200)
            send_request(random_hue(), random_level(), random_level());
        drain_results();
    endtask

    task automatic test_heavy_stall();
        gap_pct   = 10;
        stall_pct = 70;
        repeat (300)
            send_request(random_hue(), random_level(), random_level());
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= pick_gap() - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        rgb_t exp_px;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rgb.size() == 0)
            begin
                $error("unexpected result r=%0d g=%0d b=%0d", red, green, blue);
                mismatches++;
            end
            else
            begin
                exp_px = expected_rgb.pop_front();
                if (red !== exp_px.red)
                begin
                    $error("red: expected %0d, got %0d", exp_px.red, red);
                    mismatches++;
                end
                if (green !== exp_px.green)
                begin
                    $error("green: expected %0d, got %0d", exp_px.green, green);
                    mismatches++;
                end
                if (blue !== exp_px.blue)
                begin
                    $error("blue: expected %0d, got %0d", exp_px.blue, blue);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_wheel();
        test_back_to_back();
        test_heavy_stall();
        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && expected_rgb.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_sector.sv
rtl/hsv2rgb_mix.sv
rtl/hsv2rgb_select.sv
rtl/hsv_to_rgb_converter_core.sv
tb/sv/tb.sv
